FILE: src/rzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzs_pkg: shared types and constants for the rotozoom sprite sampler
// Word layouts, request and register codes, reset values, RGB565 expansion.
// ----------------------------------------------------------------------------
package rzs_pkg;

  localparam logic [1:0] REQ_TEXEL   = 2'd0;
  localparam logic [1:0] REQ_PALETTE = 2'd1;
  localparam logic [1:0] REQ_RENDER  = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COSINE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY       = 3'd5;

  localparam logic [15:0] ORG_X_RST         = 16'd8064;
  localparam logic [15:0] ORG_Y_RST         = 16'd8064;
  localparam logic [15:0] INVERSE_SCALE_RST = 16'd17809;
  localparam logic [15:0] COSINE_RST        = 16'd16384;
  localparam logic [15:0] SINE_RST          = 16'd0;
  localparam logic [15:0] OPACITY_RST       = 16'd32768;

  localparam logic [15:0] LEVEL_MIN = 16'd65;

  // c*255/31 and c*255/63 via exact reciprocal multiplies
  localparam logic [31:0] EXP5_MUL = 32'd69003255;
  localparam logic [34:0] EXP6_MUL = 35'd271631355;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] store_address;
    logic [7:0]  texel_color_index;
    logic [7:0]  texel_alpha;
    logic [15:0] palette_rgb565;
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  out_x;
    logic [5:0]  out_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] blend_alpha;
  } out_word_t;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [31:0] prod;
    prod = 32'(c) * EXP5_MUL;
    return prod[30:23];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [34:0] prod;
    prod = 35'(c) * EXP6_MUL;
    return prod[33:26];
  endfunction

endpackage

FILE: src/rotozoom_bilinear_sprite_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotozoom_bilinear_sprite_sampler: rotate/scale bilinear sprite sampler
// Loads a palette-indexed sprite and RGB565 palette, renders display pixels.
// ----------------------------------------------------------------------------
// Takes one word per cycle of any kind, back to back, unless the output stalls,
// and delivers each render result from the last divider stage. A stall on
// the output freezes the whole pipeline. The sprite lives in four banks split
// by texel row and column parity, each with one read port, so the four
// bilinear neighbors come out in the same cycle; the palette is held in four
// copies, one per neighbor. Writes land from stage 3 and are seen by every
// later render. Renders whose coverage level is 65 or less, and all writes,
// give no result.
module rotozoom_bilinear_sprite_sampler #(
  parameter int ART_SIZE      = 64,
  parameter int PALETTE_SIZE  = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rzs_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rzs_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [rzs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam int F          = FRACTION_BITS;
  localparam int CW         = $clog2(ART_SIZE);
  localparam int HALF       = (ART_SIZE + 1) / 2;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam int PAW        = $clog2(PALETTE_SIZE);
  localparam int TEXELS     = ART_SIZE * ART_SIZE;
  localparam int ROW_SHIFT  = 26;
  localparam int ROW_MUL    = ((1 << ROW_SHIFT) + ART_SIZE - 1) / ART_SIZE;
  localparam int SHR        = 36 - F;
  localparam int HALF_R     = 1 << (35 - F);
  localparam int CTR        = (ART_SIZE - 1) << (F - 1);
  localparam int SW         = 22 + F;
  localparam int WW         = 2 * F + 1;
  localparam int WAW        = 2 * F + 9;
  localparam int AW         = 2 * F + 8;
  localparam int CSW        = 2 * F + 16;
  localparam int NW         = 2 * F + 17;
  localparam int PW         = 2 * F + 24;
  localparam int LW         = 2 * F + 33;

  // configuration
  logic signed [15:0] org_x, org_y, cosine, sine;
  logic [15:0]        inverse_scale, opacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x         <= rzs_pkg::ORG_X_RST;
      org_y         <= rzs_pkg::ORG_Y_RST;
      inverse_scale <= rzs_pkg::INVERSE_SCALE_RST;
      cosine        <= rzs_pkg::COSINE_RST;
      sine          <= rzs_pkg::SINE_RST;
      opacity       <= rzs_pkg::OPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rzs_pkg::CFG_ORG_X:         org_x         <= cfg_data;
        rzs_pkg::CFG_ORG_Y:         org_y         <= cfg_data;
        rzs_pkg::CFG_INVERSE_SCALE: inverse_scale <= cfg_data;
        rzs_pkg::CFG_COSINE:        cosine        <= cfg_data;
        rzs_pkg::CFG_SINE:          sine          <= cfg_data;
        rzs_pkg::CFG_OPACITY:       opacity       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !rst;

  // stage 1: input word
  logic               v1;
  rzs_pkg::in_word_t  w1;
  logic signed [16:0] dx1, dy1;
  logic [35:0]        rprod1;
  logic               rq1, tw1, pw1;
  logic [15:0]        wdat1;

  always_comb begin
    dx1    = $signed({3'b000, w1.pixel_x, 8'h00}) - $signed({org_x[15], org_x});
    dy1    = $signed({3'b000, w1.pixel_y, 8'h00}) - $signed({org_y[15], org_y});
    rprod1 = 36'(w1.store_address) * 36'(ROW_MUL);
    rq1    = v1 && (w1.req_type == rzs_pkg::REQ_RENDER);
    tw1    = v1 && (w1.req_type == rzs_pkg::REQ_TEXEL) &&
             ({1'b0, w1.store_address} < 13'(TEXELS));
    pw1    = v1 && (w1.req_type == rzs_pkg::REQ_PALETTE) &&
             ({1'b0, w1.store_address} < 13'(PALETTE_SIZE));
    wdat1  = (w1.req_type == rzs_pkg::REQ_TEXEL) ?
             {w1.texel_alpha, w1.texel_color_index} : w1.palette_rgb565;
  end

  // stage 2
  logic               r2, tw2, pw2;
  logic [11:0]        addr2;
  logic [15:0]        wdat2;
  logic [5:0]         px2, py2;
  logic signed [16:0] dx2, dy2;
  logic [CW-1:0]      row2;
  logic signed [32:0] mx2, my2;
  logic [11:0]        cprod2, col2, bfull2;

  always_comb begin
    mx2    = 33'(cosine) * 33'(dx2) + 33'(sine) * 33'(dy2);
    my2    = 33'(cosine) * 33'(dy2) - 33'(sine) * 33'(dx2);
    cprod2 = 12'(row2) * 12'(ART_SIZE);
    col2   = addr2 - cprod2;
    bfull2 = 12'(row2[CW-1:1]) * 12'(HALF) + 12'(col2[CW-1:1]);
  end

  // stage 3: sprite and palette writes
  logic               r3, tw_en3, pw_en3;
  logic [1:0]         tw_bank3;
  logic [BAW-1:0]     tw_addr3;
  logic [PAW-1:0]     pw_addr3;
  logic [15:0]        wdat3;
  logic [5:0]         px3, py3;
  logic signed [32:0] mx3, my3;

  // stage 4
  logic               r4;
  logic [5:0]         px4, py4;
  logic [32:0]        lox4, loy4;
  logic signed [32:0] hix4, hiy4;
  logic signed [49:0] vx4, vy4;
  logic signed [SW-1:0] sx4, sy4;

  always_comb begin
    vx4 = $signed({hix4, 17'd0}) + $signed({17'd0, lox4}) + 50'(HALF_R);
    vy4 = $signed({hiy4, 17'd0}) + $signed({17'd0, loy4}) + 50'(HALF_R);
    sx4 = SW'(vx4 >>> SHR) + SW'(CTR);
    sy4 = SW'(vy4 >>> SHR) + SW'(CTR);
  end

  // stage 5: neighbor addresses and weights
  logic                 r5;
  logic [5:0]           px5, py5;
  logic signed [SW-1:0] sx5, sy5;
  logic [BAW-1:0]       raddr5 [4];
  logic                 lin5 [4];
  logic [WW-1:0]        w5 [4];

  always_comb begin
    logic signed [21:0] x0, y0, xs, ys;
    logic               ox, oy;
    logic [F:0]         wx, wy;
    logic [11:0]        afull;
    logic [2*F+1:0]     wp;
    x0 = $signed(sx5[SW-1:F]);
    y0 = $signed(sy5[SW-1:F]);
    for (int b = 0; b < 4; b++) begin
      ox    = x0[0] ^ 1'(b & 1);
      oy    = y0[0] ^ 1'(b >> 1);
      xs    = x0 + $signed({21'd0, ox});
      ys    = y0 + $signed({21'd0, oy});
      lin5[b] = !xs[21] && (xs[20:0] < 21'(ART_SIZE)) &&
                !ys[21] && (ys[20:0] < 21'(ART_SIZE));
      afull = 12'(ys[CW-1:1]) * 12'(HALF) + 12'(xs[CW-1:1]);
      raddr5[b] = afull[BAW-1:0];
      wx    = ox ? {1'b0, sx5[F-1:0]} : ((F+1)'(1 << F) - {1'b0, sx5[F-1:0]});
      wy    = oy ? {1'b0, sy5[F-1:0]} : ((F+1)'(1 << F) - {1'b0, sy5[F-1:0]});
      wp    = (2*F+2)'(wx) * (2*F+2)'(wy);
      w5[b] = wp[WW-1:0];
    end
  end

  // stage 6: texel data
  logic            r6;
  logic [5:0]      px6, py6;
  logic            lin6 [4];
  logic [WW-1:0]   w6 [4];
  logic [15:0]     tex6 [4];
  logic [PAW-1:0]  paddr6 [4];
  logic            pok6 [4];
  logic [WAW-1:0]  wa6 [4];

  always_comb begin
    logic [15:0] t;
    for (int b = 0; b < 4; b++) begin
      t         = lin6[b] ? tex6[b] : 16'h0000;
      pok6[b]   = lin6[b] && ({1'b0, t[7:0]} < 9'(PALETTE_SIZE));
      paddr6[b] = t[PAW-1:0];
      wa6[b]    = WAW'(t[15:8]) * WAW'(w6[b]);
    end
  end

  // stage 7: palette data
  logic            r7;
  logic [5:0]      px7, py7;
  logic            pok7 [4];
  logic [WAW-1:0]  wa7 [4];
  logic [15:0]     pal7 [4];
  logic [7:0]      col7 [4][3];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      col7[b][0] = pok7[b] ? rzs_pkg::expand5(pal7[b][15:11]) : 8'd0;
      col7[b][1] = pok7[b] ? rzs_pkg::expand6(pal7[b][10:5])  : 8'd0;
      col7[b][2] = pok7[b] ? rzs_pkg::expand5(pal7[b][4:0])   : 8'd0;
    end
  end

  // stage 8: weighted products
  logic            r8;
  logic [5:0]      px8, py8;
  logic [7:0]      col8 [4][3];
  logic [WAW-1:0]  wa8 [4];
  logic [CSW-1:0]  cw8 [4][3];
  logic [AW-1:0]   asum8;

  always_comb begin
    asum8 = '0;
    for (int b = 0; b < 4; b++) begin
      asum8 = asum8 + AW'(wa8[b]);
      for (int k = 0; k < 3; k++) begin
        cw8[b][k] = CSW'(col8[b][k]) * CSW'(wa8[b]);
      end
    end
  end

  // stage 9: sums
  logic            r9;
  logic [5:0]      px9, py9;
  logic [CSW-1:0]  cw9 [4][3];
  logic [AW-1:0]   asum9;
  logic [CSW-1:0]  csum9 [3];
  logic [PW-1:0]   p9;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum9[k] = cw9[0][k] + cw9[1][k] + cw9[2][k] + cw9[3][k];
    end
    p9 = PW'(asum9) * PW'(opacity);
  end

  // stage 10: coverage level
  logic            r10;
  logic [5:0]      px10, py10;
  logic [CSW-1:0]  csum10 [3];
  logic [AW-1:0]   asum10;
  logic [PW-1:0]   p10;
  logic [LW-1:0]   lsum10;
  logic [15:0]     level10;
  logic            emit10;
  logic [NW-1:0]   num10 [3];

  always_comb begin
    lsum10  = LW'({p10, 8'h00}) + LW'(p10) + (LW'(1) << (2 * F + 14));
    level10 = (p10 >= (PW'(255) << (2 * F + 15))) ? 16'hFFFF : lsum10[2*F+15 +: 16];
    emit10  = level10 > rzs_pkg::LEVEL_MIN;
    for (int k = 0; k < 3; k++) begin
      num10[k] = NW'(csum10[k]) + NW'(asum10 >> 1);
    end
  end

  // divider: one quotient bit per stage, three channels
  logic            dv   [9];
  logic [5:0]      dpx  [9];
  logic [5:0]      dpy  [9];
  logic [15:0]     dlv  [9];
  logic [7:0]      dq   [9][3];
  logic [AW-1:0]   da   [8];
  logic [NW-1:0]   drem [8][3];
  logic [NW-1:0]   rem_next [8][3];
  logic [7:0]      q_next   [8][3];

  always_comb begin
    logic [NW-1:0] trial;
    for (int j = 0; j < 8; j++) begin
      trial = NW'(da[j]) << (7 - j);
      for (int k = 0; k < 3; k++) begin
        if (drem[j][k] >= trial) begin
          rem_next[j][k] = drem[j][k] - trial;
          q_next[j][k]   = dq[j][k] | 8'(1 << (7 - j));
        end else begin
          rem_next[j][k] = drem[j][k];
          q_next[j][k]   = dq[j][k];
        end
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      r2 <= 1'b0; tw2 <= 1'b0; pw2 <= 1'b0;
      r3 <= 1'b0; tw_en3 <= 1'b0; pw_en3 <= 1'b0;
      r4 <= 1'b0; r5 <= 1'b0; r6 <= 1'b0; r7 <= 1'b0;
      r8 <= 1'b0; r9 <= 1'b0; r10 <= 1'b0;
      for (int j = 0; j < 9; j++) begin
        dv[j] <= 1'b0;
      end
    end else if (adv) begin
      v1 <= in_valid;
      r2 <= rq1; tw2 <= tw1; pw2 <= pw1;
      r3 <= r2; tw_en3 <= tw2; pw_en3 <= pw2;
      r4 <= r3; r5 <= r4; r6 <= r5; r7 <= r6;
      r8 <= r7; r9 <= r8; r10 <= r9;
      dv[0] <= r10 && emit10;
      for (int j = 0; j < 8; j++) begin
        dv[j+1] <= dv[j];
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= in_word;

      addr2 <= w1.store_address;
      wdat2 <= wdat1;
      px2   <= w1.pixel_x;
      py2   <= w1.pixel_y;
      dx2   <= dx1;
      dy2   <= dy1;
      row2  <= rprod1[ROW_SHIFT +: CW];

      tw_bank3 <= {row2[0], col2[0]};
      tw_addr3 <= bfull2[BAW-1:0];
      pw_addr3 <= addr2[PAW-1:0];
      wdat3    <= wdat2;
      px3 <= px2; py3 <= py2;
      mx3 <= mx2; my3 <= my2;

      px4  <= px3; py4 <= py3;
      lox4 <= 33'(mx3[16:0]) * 33'(inverse_scale);
      loy4 <= 33'(my3[16:0]) * 33'(inverse_scale);
      hix4 <= 33'($signed(mx3[32:17])) * 33'($signed({1'b0, inverse_scale}));
      hiy4 <= 33'($signed(my3[32:17])) * 33'($signed({1'b0, inverse_scale}));

      px5 <= px4; py5 <= py4;
      sx5 <= sx4; sy5 <= sy4;

      px6 <= px5; py6 <= py5;
      px7 <= px6; py7 <= py6;
      px8 <= px7; py8 <= py7;
      px9 <= px8; py9 <= py8;
      px10 <= px9; py10 <= py9;
      for (int b = 0; b < 4; b++) begin
        lin6[b] <= lin5[b];
        w6[b]   <= w5[b];
        pok7[b] <= pok6[b];
        wa7[b]  <= wa6[b];
        wa8[b]  <= wa7[b];
        for (int k = 0; k < 3; k++) begin
          col8[b][k] <= col7[b][k];
          cw9[b][k]  <= cw8[b][k];
        end
      end
      asum9  <= asum8;
      asum10 <= asum9;
      p10    <= p9;
      for (int k = 0; k < 3; k++) begin
        csum10[k]  <= csum9[k];
        drem[0][k] <= num10[k];
        dq[0][k]   <= 8'd0;
      end
      da[0]  <= asum10;
      dpx[0] <= px10;
      dpy[0] <= py10;
      dlv[0] <= level10;
      for (int j = 0; j < 8; j++) begin
        dpx[j+1] <= dpx[j];
        dpy[j+1] <= dpy[j];
        dlv[j+1] <= dlv[j];
        for (int k = 0; k < 3; k++) begin
          dq[j+1][k] <= q_next[j][k];
        end
      end
      for (int j = 0; j < 7; j++) begin
        da[j+1] <= da[j];
        for (int k = 0; k < 3; k++) begin
          drem[j+1][k] <= rem_next[j][k];
        end
      end
    end
  end

  // texel banks (row parity, column parity) and palette copies
  for (genvar b = 0; b < 4; b++) begin : g_lane
    logic [15:0] texel_mem [BANK_DEPTH];
    logic [15:0] pal_mem [PALETTE_SIZE];

    always_ff @(posedge clk) begin
      if (adv && tw_en3 && (tw_bank3 == 2'(b))) begin
        texel_mem[tw_addr3] <= wdat3;
      end
      if (adv) begin
        tex6[b] <= texel_mem[raddr5[b]];
      end
    end

    always_ff @(posedge clk) begin
      if (adv && pw_en3) begin
        pal_mem[pw_addr3] <= wdat3;
      end
      if (adv) begin
        pal7[b] <= pal_mem[paddr6[b]];
      end
    end
  end

  always_comb begin
    out_valid            = dv[8];
    out_word.out_x       = dpx[8];
    out_word.out_y       = dpy[8];
    out_word.red         = dq[8][0];
    out_word.green       = dq[8][1];
    out_word.blue        = dq[8][2];
    out_word.blend_alpha = dlv[8];
  end

endmodule

FILE: src/rzs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzs_checker: port-level checks for the rotozoom sprite sampler
// Output hold, stall propagation, coverage floor and reset behavior.
// ----------------------------------------------------------------------------
module rzs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rzs_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output is stalled");

  a_level_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.blend_alpha > rzs_pkg::LEVEL_MIN)
    else $error("faint pixel emitted");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rotozoom_bilinear_sprite_sampler rzs_checker u_rzs_checker (.*);

FILE: tb/sv/rotozoom_bilinear_sprite_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotozoom_bilinear_sprite_sampler_tb: self-checking bench for the sampler
// Loads sprite and palette, renders pixels under many rotate/scale settings,
// and compares each output word with a bit-exact software prediction.
// ----------------------------------------------------------------------------
module rotozoom_bilinear_sprite_sampler_tb;

  class render_scoreboard;
    rzs_pkg::out_word_t pending[$];
    int          errors;
    int          renders;
    int          emitted;
    logic [15:0] texels[4096];
    logic [15:0] palette[256];
    logic [15:0] cx, cy, inv, cs, sn, opac;

    function new();
      errors = 0; renders = 0; emitted = 0;
      cx = rzs_pkg::ORG_X_RST; cy = rzs_pkg::ORG_Y_RST;
      inv = rzs_pkg::INVERSE_SCALE_RST;
      cs = rzs_pkg::COSINE_RST; sn = rzs_pkg::SINE_RST; opac = rzs_pkg::OPACITY_RST;
    endfunction

    function void set_reg(logic [rzs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        rzs_pkg::CFG_ORG_X: cx = v;
        rzs_pkg::CFG_ORG_Y: cy = v;
        rzs_pkg::CFG_INVERSE_SCALE: inv = v;
        rzs_pkg::CFG_COSINE: cs = v;
        rzs_pkg::CFG_SINE: sn = v;
        rzs_pkg::CFG_OPACITY: opac = v;
        default: ;
      endcase
    endfunction

    function void fetch(longint x, longint y, output longint rgb[3], output longint al);
      logic [15:0] t, p;
      rgb[0] = 0; rgb[1] = 0; rgb[2] = 0; al = 0;
      if (x < 0 || x > 63 || y < 0 || y > 63) return;
      t = texels[y * 64 + x];
      al = t[15:8];
      p = palette[t[7:0]];
      rgb[0] = longint'(p[15:11]) * 255 / 31;
      rgb[1] = longint'(p[10:5]) * 255 / 63;
      rgb[2] = longint'(p[4:0]) * 255 / 31;
    endfunction

    function void note_input(rzs_pkg::in_word_t w);
      longint dx, dy, c, s, vx, vy, sx, sy, x0, y0, fx, fy;
      longint wt[4], rgb[3], al, a_sum, c_sum[3], p, den, lvl, col;
      rzs_pkg::out_word_t e;
      if (w.req_type == rzs_pkg::REQ_TEXEL) begin
        texels[w.store_address] = {w.texel_alpha, w.texel_color_index};
        return;
      end
      if (w.req_type == rzs_pkg::REQ_PALETTE) begin
        if (w.store_address < 256) palette[w.store_address[7:0]] = w.palette_rgb565;
        return;
      end
      if (w.req_type != rzs_pkg::REQ_RENDER) return;
      renders++;
      dx = longint'(w.pixel_x) * 256 - longint'($signed(cx));
      dy = longint'(w.pixel_y) * 256 - longint'($signed(cy));
      c = longint'($signed(cs));
      s = longint'($signed(sn));
      vx = (c * dx + s * dy) * longint'(inv);
      vy = (c * dy - s * dx) * longint'(inv);
      sx = ((vx + (64'sd1 <<< 27)) >>> 28) + (63 <<< 7);
      sy = ((vy + (64'sd1 <<< 27)) >>> 28) + (63 <<< 7);
      x0 = sx >>> 8; y0 = sy >>> 8;
      fx = sx - x0 * 256; fy = sy - y0 * 256;
      wt[0] = (256 - fx) * (256 - fy);
      wt[1] = fx * (256 - fy);
      wt[2] = (256 - fx) * fy;
      wt[3] = fx * fy;
      a_sum = 0; c_sum[0] = 0; c_sum[1] = 0; c_sum[2] = 0;
      for (int i = 0; i < 4; i++) begin
        fetch(x0 + (i & 1), y0 + (i >> 1), rgb, al);
        a_sum += al * wt[i];
        for (int k = 0; k < 3; k++) c_sum[k] += rgb[k] * al * wt[i];
      end
      p = a_sum * longint'(opac);
      den = 64'd255 * 64'd65536 * 64'd32768;
      if (p >= den) lvl = 65535;
      else lvl = (p * 65535 + den / 2) / den;
      if (lvl <= rzs_pkg::LEVEL_MIN) return;
      e.out_x = w.pixel_x;
      e.out_y = w.pixel_y;
      e.blend_alpha = lvl[15:0];
      for (int k = 0; k < 3; k++) begin
        col = (a_sum > 0) ? (c_sum[k] + a_sum / 2) / a_sum : 0;
        if (col > 255) col = 255;
        if (k == 0) e.red = col[7:0];
        else if (k == 1) e.green = col[7:0];
        else e.blue = col[7:0];
      end
      pending.push_back(e);
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, e, g);
      end
    endfunction

    function void check_result(rzs_pkg::out_word_t g);
      rzs_pkg::out_word_t e;
      emitted++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none got %h", $time, g);
        return;
      end
      e = pending.pop_front();
      cmp("out_x", e.out_x, g.out_x);
      cmp("out_y", e.out_y, g.out_y);
      cmp("red", e.red, g.red);
      cmp("green", e.green, g.green);
      cmp("blue", e.blue, g.blue);
      cmp("blend_alpha", e.blend_alpha, g.blend_alpha);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  rzs_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 0;
  rzs_pkg::out_word_t out_word;
  logic cfg_we = 0;
  logic [rzs_pkg::CFG_IDX_W-1:0] cfg_index = rzs_pkg::CFG_ORG_X;
  logic [15:0] cfg_data = '0;

  render_scoreboard sb = new();
  bit calm = 0;
  int stall = 0;
  int cycles = 0;

  rotozoom_bilinear_sprite_sampler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_word);
      stall = calm ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk) begin
    if (stall > 0) begin
      out_ready <= 0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1;
    end
  end

  task send_word(rzs_pkg::in_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task write_reg(logic [rzs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function rzs_pkg::in_word_t rand_word(logic [1:0] kind);
    rzs_pkg::in_word_t w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w = r[$bits(rzs_pkg::in_word_t)-1:0];
    w.req_type = kind;
    return w;
  endfunction

  function rzs_pkg::in_word_t render_at(int x, int y);
    rzs_pkg::in_word_t w;
    w = rand_word(rzs_pkg::REQ_RENDER);
    w.pixel_x = 6'(x);
    w.pixel_y = 6'(y);
    return w;
  endfunction

  task random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_word(rand_word(rzs_pkg::REQ_RENDER));
      else if (r < 85) send_word(rand_word(rzs_pkg::REQ_TEXEL));
      else if (r < 95) send_word(rand_word(rzs_pkg::REQ_PALETTE));
      else send_word(rand_word(rzs_pkg::REQ_UNUSED));
    end
  endtask

  task set_all(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d,
               logic [15:0] e, logic [15:0] f);
    drain();
    write_reg(rzs_pkg::CFG_ORG_X, a);
    write_reg(rzs_pkg::CFG_ORG_Y, b);
    write_reg(rzs_pkg::CFG_INVERSE_SCALE, c);
    write_reg(rzs_pkg::CFG_COSINE, d);
    write_reg(rzs_pkg::CFG_SINE, e);
    write_reg(rzs_pkg::CFG_OPACITY, f);
  endtask

  initial begin
    rzs_pkg::in_word_t w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // fill every texel and palette entry so no render reads unwritten memory
    calm = 1;
    for (int a = 0; a < 4096; a++) begin
      w = rand_word(rzs_pkg::REQ_TEXEL);
      w.store_address = 12'(a);
      send_word(w);
    end
    for (int a = 0; a < 256; a++) begin
      w = rand_word(rzs_pkg::REQ_PALETTE);
      w.store_address = 12'(a);
      send_word(w);
    end
    calm = 0;

    // directed
    w = rand_word(rzs_pkg::REQ_PALETTE); w.store_address = 0; w.palette_rgb565 = 16'hFFFF;
    send_word(w);
    w = rand_word(rzs_pkg::REQ_PALETTE); w.store_address = 255; w.palette_rgb565 = 16'h0000;
    send_word(w);
    w = rand_word(rzs_pkg::REQ_PALETTE); w.store_address = 4095; w.palette_rgb565 = 16'h1234;
    send_word(w);
    w = rand_word(rzs_pkg::REQ_TEXEL); w.store_address = 0;
    w.texel_color_index = 0; w.texel_alpha = 255;
    send_word(w);
    w = rand_word(rzs_pkg::REQ_TEXEL); w.store_address = 4095;
    w.texel_color_index = 255; w.texel_alpha = 0;
    send_word(w);
    w = rand_word(rzs_pkg::REQ_TEXEL); w.store_address = 2080;
    w.texel_color_index = 0; w.texel_alpha = 1;
    send_word(w);
    send_word(render_at(0, 0));
    send_word(render_at(63, 63));
    send_word(render_at(63, 0));
    send_word(render_at(0, 63));
    send_word(render_at(32, 32));
    send_word(rand_word(rzs_pkg::REQ_UNUSED));
    send_word(render_at(31, 31));
    random_items(250);

    // quarter turn, saturating opacity
    set_all(16'd8064, 16'd8064, 16'd16384, 16'd0, -16'sd16384, 16'hFFFF);
    random_items(250);
    // half turn
    set_all(16'd8064, 16'd8064, 16'd20000, -16'sd16384, 16'd0, 16'd32768);
    calm = 1;
    random_items(200);
    calm = 0;
    // zero scale: every pixel maps to the sprite center
    set_all(16'd0, 16'd0, 16'd0, 16'd16384, 16'd16384, 16'd32768);
    random_items(150);
    // widest scale, center extremes
    set_all(16'h8000, 16'h7FFF, 16'hFFFF, 16'd16384, 16'd0, 16'd32768);
    random_items(150);
    // invisible and faint
    set_all(16'd8064, 16'd8064, 16'd17809, 16'd16384, 16'd0, 16'd0);
    random_items(100);
    set_all(16'd8064, 16'd8064, 16'd17809, 16'd16384, 16'd0, 16'd300);
    random_items(100);
    for (int ph = 0; ph < 6; ph++) begin
      set_all(16'(8064 + $urandom_range(0, 8000) - 4000),
              16'(8064 + $urandom_range(0, 8000) - 4000),
              16'($urandom_range(6000, 40000)),
              16'($urandom_range(0, 32768) - 16384),
              16'($urandom_range(0, 32768) - 16384),
              16'($urandom_range(0, 40000)));
      random_items(150);
    end

    drain();
    $display("checked %0d renders, %0d output words, across 13 register settings",
             sb.renders, sb.emitted);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d words never arrived", sb.errors, sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: rotozoom_bilinear_sprite_sampler.f
src/rzs_pkg.sv
src/rotozoom_bilinear_sprite_sampler.sv
src/rzs_checker.sv
tb/sv/rotozoom_bilinear_sprite_sampler_tb.sv
